// ----- src/msh_pkg.sv -----
// Package for the multipole slab Hankel core: shared constants, state codes,
// the exp(-2^k) table and register indexes. No dependencies.
package msh_pkg;

  localparam int MAX_IMAGE_PAIRS_DEF = 15;

  // Configuration register indexes
  localparam logic [2:0] REG_THICKNESS  = 3'd0;
  localparam logic [2:0] REG_REAL_DEPTH = 3'd1;
  localparam logic [2:0] REG_VIRT_DEPTH = 3'd2;
  localparam logic [2:0] REG_EXTRAP     = 3'd3;
  localparam logic [2:0] REG_TRANSPORT  = 3'd4;
  localparam logic [2:0] REG_ABSORB     = 3'd5;
  localparam logic [2:0] REG_ALBEDO     = 3'd6;
  localparam logic [2:0] REG_PAIRS      = 3'd7;

  // Shared multiplier operand width
  localparam int MUL_W = 33;
  localparam int EXP_BITS = 21;

  // exponent at or above 22.0 (Q32.32 integer part) gives zero
  localparam logic [5:0] EXP_ZERO_INT = 6'd22;
  // exp(-x) < 1e-15 once x > 34.538776 in Q32.32
  localparam logic [37:0] EARLY_STOP_LIMIT = 38'd148342915060;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_THIN_MUL = 14'b00000000000010,
    S_SQA      = 14'b00000000000100,
    S_SQB      = 14'b00000000001000,
    S_SQRT     = 14'b00000000010000,
    S_OFF_LO   = 14'b00000000100000,
    S_OFF_HI   = 14'b00000001000000,
    S_TERM_LO  = 14'b00000010000000,
    S_TERM_HI  = 14'b00000100000000,
    S_XPREP    = 14'b00001000000000,
    S_EXP      = 14'b00010000000000,
    S_ACC      = 14'b00100000000000,
    S_SCL_LO   = 14'b01000000000000,
    S_SCL_HI   = 14'b10000000000000
  } state_t;

  // round(exp(-2^(i-16)) * 2^32)
  function automatic logic [31:0] exp_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd4294901760;
      5'd1:  v = 32'd4294836226;
      5'd2:  v = 32'd4294705160;
      5'd3:  v = 32'd4294443040;
      5'd4:  v = 32'd4293918848;
      5'd5:  v = 32'd4292870656;
      5'd6:  v = 32'd4290775039;
      5'd7:  v = 32'd4286586875;
      5'd8:  v = 32'd4278222805;
      5'd9:  v = 32'd4261543595;
      5'd10: v = 32'd4228380000;
      5'd11: v = 32'd4162825044;
      5'd12: v = 32'd4034748382;
      5'd13: v = 32'd3790295335;
      5'd14: v = 32'd3344923893;
      5'd15: v = 32'd2605029347;
      5'd16: v = 32'd1580030169;
      5'd17: v = 32'd581260615;
      5'd18: v = 32'd78665070;
      5'd19: v = 32'd1440801;
      5'd20: v = 32'd483;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/multipole_slab_hankel_core.sv -----
// Top level of the multipole slab Hankel core: sequencer around one shared
// 33x33 multiplier, a bit-serial square root and the exp table.
// Depends on msh_pkg.
//
// One frequency beat in, one R/T beat out. The core holds in_tready low while it
// works on a beat; everything runs through a single 33x33 multiplier, so the
// time per beat is set by that unit and the sequencer. A thin slab (thickness
// below real depth) takes the absorption product, exponent prep, the exp pass and
// the result step. Otherwise: the squares, the square root, the image offset, then
// for each image period four terms of product halves, exponent prep, exp pass
// and accumulation, where the exp pass is skipped if the term underflows, and
// finally albedo scaling. Periods run from -N to N and stop early on the far side
// once the real source is too deep. The result sits in an output register; the
// next beat is taken once the core is back in idle and that register is free.
// Configuration is accepted at any time and must be written idle.
module multipole_slab_hankel_core
  import msh_pkg::*;
#(
  parameter int MAX_IMAGE_PAIRS = MAX_IMAGE_PAIRS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] freq_sample
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  // out_tdata: [31:0] reflect_value, [63:32] transmit_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CL  = $clog2(MAX_IMAGE_PAIRS + 1);
  localparam int N_W = CL + 1;
  localparam int J_W = N_W + 1;
  localparam int Z_W = 37 + CL + 1;
  localparam int P_W = Z_W + MUL_W + 1;
  localparam int S_W = 31 + CL + 3 + 1;
  localparam int PER_W = 35;

  // configuration registers
  logic [31:0] thick_r, zr_r, zv_r, de_r, str_r, sa_r;
  logic [16:0] alb_r;
  logic [3:0]  pairs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= 32'd65536;
      zr_r    <= 32'd65536;
      zv_r    <= 32'd131072;
      de_r    <= 32'd32768;
      str_r   <= 32'd65536;
      sa_r    <= 32'd0;
      alb_r   <= 17'd65536;
      pairs_r <= 4'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THICKNESS:  thick_r <= cfg_data;
        REG_REAL_DEPTH: zr_r    <= cfg_data;
        REG_VIRT_DEPTH: zv_r    <= cfg_data;
        REG_EXTRAP:     de_r    <= cfg_data;
        REG_TRANSPORT:  str_r   <= cfg_data;
        REG_ABSORB:     sa_r    <= cfg_data;
        REG_ALBEDO:     alb_r   <= cfg_data[16:0];
        REG_PAIRS:      pairs_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // working state
  state_t state_r, state_nxt;
  logic [31:0] s_r, s_nxt;
  logic        last_r, last_nxt, thin_r, thin_nxt;
  logic [63:0] a2_r, a2_nxt, rem_r, rem_nxt, root_r, root_nxt, bitv_r, bitv_nxt;
  logic        dbl_r, dbl_nxt;
  logic [32:0] q_r, q_nxt;
  logic signed [Z_W-1:0] off_r, off_nxt;
  logic signed [J_W-1:0] j_r, j_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [Z_W-1:0] a_r, a_nxt;
  logic        zneg_r, zneg_nxt, zero_r, zero_nxt, far_r, far_nxt, sel_r, sel_nxt;
  logic [P_W-1:0] prod_r, prod_nxt;
  logic [EXP_BITS-1:0] x_r, x_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic signed [S_W-1:0] rsum_r, rsum_nxt, tsum_r, tsum_nxt;
  logic [31:0] refl_r, refl_nxt, trans_r, trans_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic        ol_r, ol_nxt;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // derived values
  logic [N_W-1:0] n_lim;
  logic [PER_W-1:0] period;
  logic signed [Z_W-1:0] z0, z1, z2, z3, zsel, zr_s, zv_s, d_s, per_s;
  logic [Z_W-1:0] zabs;
  logic signed [S_W-1:0] sum_sel;
  logic [64:0] sq_sum;
  logic [63:0] sq_try;
  logic [30:0] eterm;
  logic signed [S_W-1:0] eterm_s;
  logic [P_W-1:0] prod_add;
  logic [P_W-1:0] scl_v;

  always_comb begin
    if (32'(pairs_r) > 32'(MAX_IMAGE_PAIRS)) n_lim = N_W'(MAX_IMAGE_PAIRS);
    else n_lim = N_W'(pairs_r);
  end

  assign period = {34'(thick_r) + {1'b0, de_r, 1'b0}, 1'b0};
  assign zr_s  = Z_W'(zr_r);
  assign zv_s  = Z_W'(zv_r);
  assign d_s   = Z_W'(thick_r);
  assign per_s = Z_W'(period);
  assign z0 = zr_s + off_r;
  assign z1 = off_r - zv_s;
  assign z2 = d_s - z0;
  assign z3 = d_s - z1;

  // source distance for the current term
  always_comb begin
    unique case (k_r)
      2'd0: zsel = z0;
      2'd1: zsel = z1;
      2'd2: zsel = z2;
      2'd3: zsel = z3;
      default: zsel = z0;
    endcase
  end
  assign zabs = zsel[Z_W-1] ? Z_W'(-zsel) : Z_W'(zsel);
  assign sum_sel = sel_r ? tsum_r : rsum_r;
  assign sq_sum = {1'b0, a2_r} + {1'b0, mul_p[63:0]};
  assign sq_try = root_r + bitv_r;
  assign eterm = zero_r ? 31'd0 : 31'((acc_r + 33'd2) >> 2);
  assign eterm_s = S_W'(eterm);
  assign prod_add = prod_r + (P_W'(mul_p) << MUL_W);
  assign scl_v = (prod_add + P_W'(17'h10000)) >> 17;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_THIN_MUL: begin mul_a = MUL_W'(sa_r);  mul_b = MUL_W'(thick_r); end
      S_SQA:      begin mul_a = MUL_W'(str_r); mul_b = MUL_W'(str_r); end
      S_SQB:      begin mul_a = MUL_W'(s_r);   mul_b = MUL_W'(s_r); end
      S_OFF_LO:   begin mul_a = period[MUL_W-1:0]; mul_b = MUL_W'(n_lim); end
      S_OFF_HI:   begin mul_a = MUL_W'(period[PER_W-1:MUL_W]); mul_b = MUL_W'(n_lim); end
      S_TERM_LO:  begin mul_a = zabs[MUL_W-1:0]; mul_b = q_r; end
      S_TERM_HI:  begin mul_a = MUL_W'(a_r[Z_W-1:MUL_W]); mul_b = q_r; end
      S_EXP:      begin mul_a = acc_r; mul_b = MUL_W'(exp_entry(bit_r)); end
      S_SCL_LO:   begin mul_a = sum_sel[MUL_W-1:0]; mul_b = MUL_W'(alb_r); end
      S_SCL_HI:   begin mul_a = MUL_W'(sum_sel[S_W-1:MUL_W]); mul_b = MUL_W'(alb_r); end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r; last_nxt = last_r; thin_nxt = thin_r;
    a2_nxt = a2_r; rem_nxt = rem_r; root_nxt = root_r; bitv_nxt = bitv_r;
    dbl_nxt = dbl_r; q_nxt = q_r; off_nxt = off_r; j_nxt = j_r; k_nxt = k_r;
    a_nxt = a_r; zneg_nxt = zneg_r; zero_nxt = zero_r; far_nxt = far_r;
    sel_nxt = sel_r; prod_nxt = prod_r; x_nxt = x_r; bit_nxt = bit_r;
    acc_nxt = acc_r; rsum_nxt = rsum_r; tsum_nxt = tsum_r;
    refl_nxt = refl_r; trans_nxt = trans_r;
    ov_nxt = ov_r; od_nxt = od_r; ol_nxt = ol_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          s_nxt = in_tdata;
          last_nxt = in_tlast;
          thin_nxt = thick_r < zr_r;
          rsum_nxt = '0;
          tsum_nxt = '0;
          sel_nxt = 1'b0;
          state_nxt = (thick_r < zr_r) ? S_THIN_MUL : S_SQA;
        end
      end
      S_THIN_MUL: begin
        prod_nxt = P_W'(mul_p);
        state_nxt = S_XPREP;
      end
      S_SQA: begin
        a2_nxt = mul_p[63:0];
        state_nxt = S_SQB;
      end
      S_SQB: begin
        // sum of squares, or quarters of each if it overflows 64 bits
        dbl_nxt = sq_sum[64];
        rem_nxt = sq_sum[64] ? (a2_r >> 2) + (mul_p[63:0] >> 2) : sq_sum[63:0];
        root_nxt = '0;
        bitv_nxt = 64'h4000_0000_0000_0000;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // one result bit a cycle
        if (rem_r >= sq_try) begin
          rem_nxt = rem_r - sq_try;
          root_nxt = (root_r >> 1) + bitv_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bitv_nxt = bitv_r >> 2;
        if (bitv_r[0]) begin
          q_nxt = dbl_r ? {root_nxt[31:0], 1'b0} : {1'b0, root_nxt[31:0]};
          state_nxt = S_OFF_LO;
        end
      end
      S_OFF_LO: begin
        prod_nxt = P_W'(mul_p);
        state_nxt = S_OFF_HI;
      end
      S_OFF_HI: begin
        // first image offset is -N * period
        off_nxt = Z_W'(-$signed({1'b0, prod_add}));
        j_nxt = -$signed(J_W'(n_lim));
        k_nxt = 2'd0;
        state_nxt = S_TERM_LO;
      end
      S_TERM_LO: begin
        a_nxt = zabs;
        zneg_nxt = zsel[Z_W-1];
        prod_nxt = P_W'(mul_p);
        state_nxt = S_TERM_HI;
      end
      S_TERM_HI: begin
        prod_nxt = prod_add;
        state_nxt = S_XPREP;
      end
      S_XPREP: begin
        zero_nxt = prod_r[P_W-1:32] >= (P_W-32)'(EXP_ZERO_INT);
        x_nxt = EXP_BITS'((prod_r + P_W'(16'h8000)) >> 16);
        if (k_r == 2'd0) far_nxt = prod_r > P_W'(EARLY_STOP_LIMIT);
        acc_nxt = 33'h1_0000_0000;
        bit_nxt = '0;
        state_nxt = prod_r[P_W-1:32] >= (P_W-32)'(EXP_ZERO_INT) ? S_ACC : S_EXP;
      end
      S_EXP: begin
        // product of table entries for set exponent bits
        if (x_r[bit_r]) acc_nxt = 33'((mul_p + 66'h8000_0000) >> 32);
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'(EXP_BITS - 1)) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (thin_r) begin
          refl_nxt = '0;
          trans_nxt = 32'(eterm);
          state_nxt = S_IDLE;
          ov_nxt = 1'b1;
        end else begin
          if (zneg_r ^ k_r[0]) begin
            if (k_r[1]) tsum_nxt = tsum_r - eterm_s;
            else rsum_nxt = rsum_r - eterm_s;
          end else begin
            if (k_r[1]) tsum_nxt = tsum_r + eterm_s;
            else rsum_nxt = rsum_r + eterm_s;
          end
          if (k_r != 2'd3) begin
            k_nxt = k_r + 2'd1;
            state_nxt = S_TERM_LO;
          end else if (j_r == $signed(J_W'(n_lim)) ||
                       (j_r > 0 && q_r != '0 && far_r)) begin
            state_nxt = S_SCL_LO;
          end else begin
            j_nxt = j_r + J_W'(1);
            off_nxt = off_r + per_s;
            k_nxt = 2'd0;
            state_nxt = S_TERM_LO;
          end
        end
      end
      S_SCL_LO: begin
        prod_nxt = P_W'(mul_p);
        if (sum_sel <= 0) begin
          if (sel_r) trans_nxt = '0;
          else refl_nxt = '0;
          sel_nxt = 1'b1;
          if (sel_r) begin
            state_nxt = S_IDLE;
            ov_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_SCL_HI;
        end
      end
      S_SCL_HI: begin
        // round, drop 17 bits, saturate
        if (sel_r) trans_nxt = (scl_v > P_W'(32'hFFFF_FFFF)) ? '1 : scl_v[31:0];
        else refl_nxt = (scl_v > P_W'(32'hFFFF_FFFF)) ? '1 : scl_v[31:0];
        sel_nxt = 1'b1;
        if (sel_r) begin
          state_nxt = S_IDLE;
          ov_nxt = 1'b1;
        end else begin
          state_nxt = S_SCL_LO;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // result beat into the output register
    if (state_r != S_IDLE && state_nxt == S_IDLE) begin
      od_nxt = {trans_nxt, refl_nxt};
      ol_nxt = last_r;
    end
  end

  // ready only in idle and once the output register is free
  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= (state_r == S_IDLE && !in_tready) ? S_IDLE : state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!(state_r == S_IDLE && !in_tready)) begin
      s_r <= s_nxt; last_r <= last_nxt; thin_r <= thin_nxt;
      a2_r <= a2_nxt; rem_r <= rem_nxt; root_r <= root_nxt; bitv_r <= bitv_nxt;
      dbl_r <= dbl_nxt; q_r <= q_nxt; off_r <= off_nxt; j_r <= j_nxt; k_r <= k_nxt;
      a_r <= a_nxt; zneg_r <= zneg_nxt; zero_r <= zero_nxt; far_r <= far_nxt;
      sel_r <= sel_nxt; prod_r <= prod_nxt; x_r <= x_nxt; bit_r <= bit_nxt;
      acc_r <= acc_nxt; rsum_r <= rsum_nxt; tsum_r <= tsum_nxt;
      refl_r <= refl_nxt; trans_r <= trans_nxt;
      od_r <= od_nxt; ol_r <= ol_nxt;
    end
  end

endmodule

// ----- tb/tb_multipole_slab_hankel_core.sv -----
// Testbench for multipole_slab_hankel_core: directed and random frequency beats under
// several slab settings, checked against a bit-accurate predictor held in a scoreboard class.
// Depends on msh_pkg and the core RTL.
module tb_multipole_slab_hankel_core;
  import msh_pkg::*;

  typedef struct {
    bit [31:0] refl;
    bit [31:0] trans;
    bit        last;
  } slab_result_t;

  // Predictor of the slab response and store of pending results
  class slab_scoreboard;
    bit [31:0]    regs [8];
    slab_result_t pending [$];
    int           errors;
    bit [31:0]    exp_tab [21] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
      32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
      32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
      32'd2605029347, 32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801, 32'd483};

    function void set_reset_values();
      regs[REG_THICKNESS]  = 32'd65536;
      regs[REG_REAL_DEPTH] = 32'd65536;
      regs[REG_VIRT_DEPTH] = 32'd131072;
      regs[REG_EXTRAP]     = 32'd32768;
      regs[REG_TRANSPORT]  = 32'd65536;
      regs[REG_ABSORB]     = 32'd0;
      regs[REG_ALBEDO]     = 32'd65536;
      regs[REG_PAIRS]      = 32'd4;
      errors = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
      if (idx == REG_ALBEDO) regs[idx] = val & 32'h1FFFF;
      else if (idx == REG_PAIRS) regs[idx] = val & 32'hF;
      else regs[idx] = val;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // exp(-x), x exact in Q32.32, answer in Q2.30
    function bit [63:0] neg_exp(bit [63:0] x64);
      bit [63:0] x, acc;
      acc = 64'd1 << 32;
      if (x64 >= (64'd22 << 32)) return 0;
      x = (x64 + 64'h8000) >> 16;
      for (int i = 0; i < 21; i++)
        if (x[i]) acc = (acc * exp_tab[i] + (64'd1 << 31)) >> 32;
      return (acc + 2) >> 2;
    endfunction

    function longint signed_decay(longint z, bit [63:0] q);
      bit [63:0] a, e;
      a = (z < 0) ? -z : z;
      if (a == 0 || q == 0) e = neg_exp(0);
      else if (q > (64'd22 << 32) / a) e = 0;
      else e = neg_exp(a * q);
      return (z >= 0) ? longint'(e) : -longint'(e);
    endfunction

    function bit [31:0] albedo_scale(longint sum);
      bit [63:0] v;
      if (sum <= 0) return 0;
      v = 64'(sum) * regs[REG_ALBEDO];
      v = (v + (64'd1 << 16)) >> 17;
      return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function void note_input(bit [31:0] s, bit last);
      slab_result_t res;
      bit [63:0] a2, b2, sq, q;
      longint d, period, off, zreal, zvirt, rsum, tsum;
      int n;
      res.last = last;
      rsum = 0;
      tsum = 0;
      if (regs[REG_THICKNESS] < regs[REG_REAL_DEPTH]) begin
        res.refl  = 0;
        res.trans = neg_exp(64'(regs[REG_ABSORB]) * regs[REG_THICKNESS]);
        pending.push_back(res);
        return;
      end
      a2 = 64'(regs[REG_TRANSPORT]) * regs[REG_TRANSPORT];
      b2 = 64'(s) * s;
      sq = a2 + b2;
      if (sq < a2) q = 2 * int_sqrt((a2 >> 2) + (b2 >> 2));
      else q = int_sqrt(sq);
      d = regs[REG_THICKNESS];
      period = 2 * (d + 2 * longint'(regs[REG_EXTRAP]));
      n = regs[REG_PAIRS];
      if (n > MAX_IMAGE_PAIRS_DEF) n = MAX_IMAGE_PAIRS_DEF;
      for (int j = -n; j <= n; j++) begin
        off   = j * period;
        zreal = longint'(regs[REG_REAL_DEPTH]) + off;
        zvirt = off - longint'(regs[REG_VIRT_DEPTH]);
        rsum += signed_decay(zreal, q);
        rsum -= signed_decay(zvirt, q);
        tsum += signed_decay(d - zreal, q);
        tsum -= signed_decay(d - zvirt, q);
        if (j > 0 && q != 0)
          if (64'(zreal) > 64'd148342915060 / q) break;
      end
      res.refl  = albedo_scale(rsum);
      res.trans = albedo_scale(tsum);
      pending.push_back(res);
    endfunction

    function void check_result(bit [31:0] refl, bit [31:0] trans, bit last);
      slab_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat R=%h T=%h last=%b", $time, refl, trans, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.refl !== refl) begin
        $display("%0t: reflectance expected %h actual %h", $time, e.refl, refl);
        errors++;
      end
      if (e.trans !== trans) begin
        $display("%0t: transmittance expected %h actual %h", $time, e.trans, trans);
        errors++;
      end
      if (e.last !== last) begin
        $display("%0t: last flag expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [63:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  slab_scoreboard sb;
  bit  calm;          // long stretch without idling
  int  quiet_cycles;

  multipole_slab_hankel_core u_dut (.*);

  initial clk = 0;
  always #10 clk = ~clk;

  // Receiver: random stall, check on every accepted beat
  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 26);
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tdata[63:32], out_tlast);

  // Watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sample(bit [31:0] s, bit last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= s;
    in_tlast  <= last;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    sb.note_input(s, last);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_slab(bit [31:0] d, bit [31:0] zr, bit [31:0] zv, bit [31:0] de,
                          bit [31:0] tr, bit [31:0] ab, bit [31:0] alb, bit [31:0] np);
    drain();
    write_cfg(REG_THICKNESS, d);
    write_cfg(REG_REAL_DEPTH, zr);
    write_cfg(REG_VIRT_DEPTH, zv);
    write_cfg(REG_EXTRAP, de);
    write_cfg(REG_TRANSPORT, tr);
    write_cfg(REG_ABSORB, ab);
    write_cfg(REG_ALBEDO, alb);
    write_cfg(REG_PAIRS, np);
  endtask

  function automatic bit [31:0] pick_freq();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h8000);
      default: return $urandom_range(0, 32'h60000);
    endcase
  endfunction

  task automatic random_grid(int count);
    for (int k = 0; k < count; k++)
      send_sample(pick_freq(), (k % 8 == 7) || ($urandom_range(9) == 0));
  endtask

  initial begin
    sb = new();
    sb.set_reset_values();
    calm = 0;
    quiet_cycles = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    out_tready = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Reset settings: frequency extremes and both last values
    send_sample(32'h0, 0);
    send_sample(32'hFFFFFFFF, 1);
    send_sample(32'h1, 0);
    send_sample(32'h80000000, 1);
    send_sample(32'h10000, 0);
    send_sample(32'h7FFFFFFF, 0);

    // Thin slab, Beer law path
    set_slab(32'h8000, 32'h10000, 32'h20000, 32'h8000, 32'h10000, 32'h18000, 32'h10000, 32'd4);
    send_sample(32'h0, 0);
    send_sample(32'hFFFFFFFF, 1);
    // All registers at their maximum; sum of squares overflows
    set_slab(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_sample(32'hFFFFFFFF, 1);
    send_sample(32'h0, 0);
    send_sample(32'h12345678, 0);
    // Everything zero: q = 0 for s = 0, no early stop
    set_slab(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFFFF0);
    send_sample(32'h0, 1);
    send_sample(32'h20000, 0);
    // Albedo above one, full image count
    set_slab(32'h20000, 32'h8000, 32'h14000, 32'h6000, 32'h8000, 32'h0, 32'h1FFFF, 32'd15);
    send_sample(32'h0, 0);
    send_sample(32'h4000, 0);
    send_sample(32'h40000, 1);
    // Virtual source shallow, sums may go negative; single period
    set_slab(32'h10000, 32'h10000, 32'h0, 32'h0, 32'h2000, 32'h0, 32'h10000, 32'd0);
    send_sample(32'h0, 0);
    send_sample(32'h30000, 1);

    // Random slabs, mostly thick enough for the image sum
    for (int ph = 0; ph < 12; ph++) begin
      set_slab($urandom_range(32'h2000, 32'h40000), $urandom_range(32'h800, 32'h30000),
               $urandom_range(32'h0, 32'h40000), $urandom_range(32'h0, 32'h20000),
               $urandom_range(32'h0, 32'h40000), $urandom_range(32'h0, 32'h40000),
               {15'($urandom_range(0, 32'h7FFF)), 17'(($urandom_range(3) == 0) ?
                  $urandom_range(0, 32'h1FFFF) : $urandom_range(32'hC000, 32'h10000))},
               {28'($urandom), 4'($urandom_range(0, 6))});
      calm = (ph == 5);
      random_grid(18);
      if (ph == 7) drain();   // let every result arrive mid-run
      random_grid(17);
    end
    calm = 0;

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/msh_pkg.sv
src/multipole_slab_hankel_core.sv
tb/tb_multipole_slab_hankel_core.sv
